@@ hw/rtl/sgf_pkg.sv @@
// Shared types, register codes and reset values of the symbol gradient fill.
// Has no dependencies; most other files of the block refer to it by scoped names.
package sgf_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int DIM_BITS       = 13;
	localparam int CFG_IDX_BITS   = 3;
	localparam int CFG_DATA_BITS  = 32;

	localparam logic [CFG_IDX_BITS-1:0] REG_FILL_MODE      = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_INSIDE_COLOR_A = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_INSIDE_COLOR_B = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_COLOR_A   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_COLOR_B   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_POINT   = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_END_POINT      = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_DIMS     = 3'd7;

	localparam logic [1:0] MODE_SOLID  = 2'd0;
	localparam logic [1:0] MODE_LINEAR = 2'd1;
	localparam logic [1:0] MODE_RADIAL = 2'd2;

	localparam logic [31:0] CENTER_RESET = 32'h2000_2000;
	localparam logic [31:0] END_RESET    = 32'h4000_4000;
	localparam logic [28:0] DIMS_RESET   = 29'h0100_0100;

	// Per-pixel information that rides alongside the arithmetic.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       hint;
		logic       outside;
		logic       border;
	} pix_meta_t;

endpackage

@@ hw/rtl/sgf_if.sv @@
// Channel interfaces of the symbol gradient fill: pixel requests, results and register writes.
// Depends on sgf_pkg for the configuration widths.
interface sgf_pix_in_if #(
	parameter int COORD_BITS = sgf_pkg::COORD_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] x_pos;
	logic [COORD_BITS-1:0] y_pos;
	logic [7:0]            red_in;
	logic [7:0]            green_in;
	logic [7:0]            blue_in;
	logic [7:0]            alpha_in;

	modport source (output valid, x_pos, y_pos, red_in, green_in, blue_in, alpha_in,
		input ready);
	modport sink (input valid, x_pos, y_pos, red_in, green_in, blue_in, alpha_in,
		output ready);
endinterface

interface sgf_pix_out_if ();
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic [7:0] alpha_out;

	modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
	modport sink (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

interface sgf_cfg_if ();
	logic                               valid;
	logic                               ready;
	logic [sgf_pkg::CFG_IDX_BITS-1:0]   index;
	logic [sgf_pkg::CFG_DATA_BITS-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/symbol_gradient_fill.sv @@
// Top level of the symbol gradient fill: registers, pixel pipeline and colour mixing.
// Depends on sgf_pkg, the interfaces in sgf_if, sgf_ctrl, sgf_fdiv and sgf_isqrt.
//
//   Channel    Direction  Carries                                     Handshake
//   pixel      in         x_pos, y_pos, red/green/blue/alpha_in       valid/ready
//   filtered   out        red/green/blue/alpha_out                    valid/ready
//   cfg        in         index (0..7), data (32 bits)                valid/ready, ready tied high
//
// One pixel request is taken in every cycle unless an output stall has filled the pipeline.
// The depth is set by the position divider (FRAC_BITS stages) followed by the
// linear-gradient divider (FRAC_BITS stages), which runs in step with the square root
// of the radial mode (FRAC_BITS+1 stages).
// Reset clears all valid bits and returns the registers to their documented values.
// Each stage holds only while it is full and the stage after it cannot move, so a stall
// at the output fills the bubbles first and only then drops ready on the input.
// The register values are read directly by the stages that use them; they must only
// change while no pixel request is in flight.
module symbol_gradient_fill #(
	parameter int COORD_BITS = sgf_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = sgf_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sgf_pix_in_if.sink  pixel,
	sgf_pix_out_if.source filtered,
	sgf_cfg_if.sink     cfg
);

	localparam int F       = FRAC_BITS;
	localparam int DB      = sgf_pkg::DIM_BITS;
	localparam int LW      = 2 * F + 6;          // dot magnitude and squared length
	localparam int STAGES  = 2 * F + 7;
	localparam int ST_MUL  = F + 1;              // offsets times direction, squares
	localparam int ST_SUM  = F + 2;              // dot product and radial radicand
	localparam int ST_ABS  = F + 3;              // magnitude of the dot product
	localparam int ST_T    = 2 * F + 4;          // gradient parameter chosen
	localparam int ST_PROD = 2 * F + 5;          // channel weights multiplied
	localparam int ST_OUT  = 2 * F + 6;          // result register
	localparam int SHL     = (F >= 14) ? F - 14 : 0;
	localparam int SHR     = (F >= 14) ? 0 : 14 - F;
	localparam logic [F:0]    ONE_T    = (F+1)'(1) << F;
	localparam logic [F:0]    HALF_U   = (F+1)'(1) << (F - 1);
	localparam logic [LW-1:0] LEN_ONE  = LW'(1) << (2 * F);
	localparam logic [F+8:0]  ROUND_HF = (F+9)'(1) << (F - 1);

	// Configuration registers.
	logic [1:0]  fill_mode_q;
	logic [23:0] inside_a_q;
	logic [23:0] inside_b_q;
	logic [23:0] border_a_q;
	logic [23:0] border_b_q;
	logic [31:0] center_q;
	logic [31:0] end_q;
	logic [28:0] dims_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_mode_q <= sgf_pkg::MODE_SOLID;
			inside_a_q  <= '0;
			inside_b_q  <= '0;
			border_a_q  <= '0;
			border_b_q  <= '0;
			center_q    <= sgf_pkg::CENTER_RESET;
			end_q       <= sgf_pkg::END_RESET;
			dims_q      <= sgf_pkg::DIMS_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				sgf_pkg::REG_FILL_MODE:      fill_mode_q <= cfg.data[1:0];
				sgf_pkg::REG_INSIDE_COLOR_A: inside_a_q  <= cfg.data[23:0];
				sgf_pkg::REG_INSIDE_COLOR_B: inside_b_q  <= cfg.data[23:0];
				sgf_pkg::REG_EDGE_COLOR_A:   border_a_q  <= cfg.data[23:0];
				sgf_pkg::REG_EDGE_COLOR_B:   border_b_q  <= cfg.data[23:0];
				sgf_pkg::REG_CENTER_POINT:   center_q    <= cfg.data;
				sgf_pkg::REG_END_POINT:      end_q       <= cfg.data;
				sgf_pkg::REG_IMAGE_DIMS:     dims_q      <= cfg.data[28:0];
				default:                     fill_mode_q <= fill_mode_q;
			endcase
		end
	end

	// Gradient geometry derived from the registers. Points in Q2.14 become fractions with
	// 2^-F units, rounded towards minus infinity by the arithmetic shift.
	logic signed [31:0]  cxw, cyw, exw, eyw;
	logic signed [F+1:0] cx, cy, ex_abs, ey_abs;
	logic signed [F+1:0] cx_q, cy_q;
	logic signed [F+2:0] ex_q, ey_q;
	logic signed [2*F+5:0] exx, eyy;
	logic [LW-1:0]       len_sum;
	logic [LW-1:0]       len_q;

	always_comb begin
		cxw    = ($signed({{16{center_q[15]}}, center_q[15:0]}) <<< SHL) >>> SHR;
		cyw    = ($signed({{16{center_q[31]}}, center_q[31:16]}) <<< SHL) >>> SHR;
		exw    = ($signed({{16{end_q[15]}}, end_q[15:0]}) <<< SHL) >>> SHR;
		eyw    = ($signed({{16{end_q[31]}}, end_q[31:16]}) <<< SHL) >>> SHR;
		cx     = cxw[F+1:0];
		cy     = cyw[F+1:0];
		ex_abs = exw[F+1:0];
		ey_abs = eyw[F+1:0];
		exx    = (2*F+6)'(ex_q) * (2*F+6)'(ex_q);
		eyy    = (2*F+6)'(ey_q) * (2*F+6)'(ey_q);
		len_sum = LW'($unsigned(exx)) + LW'($unsigned(eyy));
	end

	always_ff @(posedge clk) begin
		cx_q  <= cx;
		cy_q  <= cy;
		ex_q  <= $signed({ex_abs[F+1], ex_abs}) - $signed({cx[F+1], cx});
		ey_q  <= $signed({ey_abs[F+1], ey_abs}) - $signed({cy[F+1], cy});
		// A gradient of zero length counts as length one.
		len_q <= (len_sum == '0) ? LEN_ONE : len_sum;
	end

	// Pipeline control and the per-pixel side line.
	sgf_pkg::pix_meta_t meta_in;
	sgf_pkg::pix_meta_t meta [STAGES];
	logic [STAGES-1:0]  valid;
	logic [STAGES-1:0]  en;

	always_comb begin
		meta_in.red     = pixel.red_in;
		meta_in.green   = pixel.green_in;
		meta_in.blue    = pixel.blue_in;
		meta_in.alpha   = pixel.alpha_in;
		meta_in.hint    = pixel.red_in != pixel.blue_in;
		meta_in.outside = (pixel.green_in != '0) && (pixel.red_in == '0);
		meta_in.border  = pixel.green_in != '0;
	end

	sgf_ctrl #(
		.STAGES(STAGES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.meta_in   (meta_in),
		.out_ready (filtered.ready),
		.valid     (valid),
		.en        (en),
		.meta      (meta)
	);

	// Input stage: the position of the pixel.
	logic [COORD_BITS-1:0] x_s0, y_s0;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s0 <= pixel.x_pos;
			y_s0 <= pixel.y_pos;
		end
	end

	// Position to fraction: u = x * 2^F / width, saturated below one when x reaches the width.
	// A width or height of zero counts as one.
	logic [DB-1:0] width, height, x_num, y_num;
	logic [F-1:0]  u_quo, v_quo, u_frac, v_frac;
	logic          u_sat, v_sat;

	always_comb begin
		width  = (dims_q[12:0] == '0) ? DB'(1) : dims_q[12:0];
		height = (dims_q[28:16] == '0) ? DB'(1) : dims_q[28:16];
		x_num  = DB'(x_s0);
		y_num  = DB'(y_s0);
	end

	sgf_fdiv #(
		.W(DB), .STEPS(F)
	) u_div_x (
		.clk     (clk),
		.en      (en[F:1]),
		.num     (x_num),
		.den     (width),
		.sat_in  (x_num >= width),
		.quo     (u_quo),
		.sat_out (u_sat)
	);

	sgf_fdiv #(
		.W(DB), .STEPS(F)
	) u_div_y (
		.clk     (clk),
		.en      (en[F:1]),
		.num     (y_num),
		.den     (height),
		.sat_in  (y_num >= height),
		.quo     (v_quo),
		.sat_out (v_sat)
	);

	assign u_frac = u_sat ? '1 : u_quo;
	assign v_frac = v_sat ? '1 : v_quo;

	// Offsets from the centre times the direction (linear) and offsets from the image
	// middle squared (radial).
	logic signed [F+2:0]   ax, ay;
	logic signed [F:0]     du, dv;
	logic signed [2*F+1:0] du_sq, dv_sq;
	logic signed [2*F+5:0] px_smul, py_smul;
	logic [2*F-1:0]        sqx_smul, sqy_smul;

	always_comb begin
		ax    = $signed({3'b000, u_frac}) - $signed({cx_q[F+1], cx_q});
		ay    = $signed({3'b000, v_frac}) - $signed({cy_q[F+1], cy_q});
		du    = $signed({1'b0, u_frac}) - $signed(HALF_U);
		dv    = $signed({1'b0, v_frac}) - $signed(HALF_U);
		du_sq = (2*F+2)'(du) * (2*F+2)'(du);
		dv_sq = (2*F+2)'(dv) * (2*F+2)'(dv);
	end

	always_ff @(posedge clk) begin
		if (en[ST_MUL]) begin
			px_smul  <= (2*F+6)'(ax) * (2*F+6)'(ex_q);
			py_smul  <= (2*F+6)'(ay) * (2*F+6)'(ey_q);
			sqx_smul <= du_sq[2*F-1:0];
			sqy_smul <= dv_sq[2*F-1:0];
		end
	end

	logic signed [2*F+6:0] dot_ssum;
	logic [2*F+1:0]        rad_ssum;

	always_ff @(posedge clk) begin
		if (en[ST_SUM]) begin
			dot_ssum <= $signed({px_smul[2*F+5], px_smul}) + $signed({py_smul[2*F+5], py_smul});
			rad_ssum <= ({2'b00, sqx_smul} + {2'b00, sqy_smul}) << 1;
		end
	end

	logic [2*F+6:0] dot_neg;
	logic [LW-1:0]  num_sabs;

	assign dot_neg = -dot_ssum;

	always_ff @(posedge clk) begin
		if (en[ST_ABS]) begin
			num_sabs <= dot_ssum[2*F+6] ? dot_neg[LW-1:0] : LW'($unsigned(dot_ssum));
		end
	end

	// Linear parameter: dot / length squared, one whenever the dot reaches the length squared.
	logic [F-1:0] lin_quo;
	logic         lin_sat;

	sgf_fdiv #(
		.W(LW), .STEPS(F)
	) u_div_lin (
		.clk     (clk),
		.en      (en[2*F+3:F+4]),
		.num     (num_sabs),
		.den     (len_q),
		.sat_in  (num_sabs >= len_q),
		.quo     (lin_quo),
		.sat_out (lin_sat)
	);

	// Radial parameter: square root of twice the squared distance from the middle.
	logic [F:0] rad_root;

	sgf_isqrt #(
		.RB(F + 1)
	) u_sqrt (
		.clk      (clk),
		.en       (en[2*F+3:F+3]),
		.radicand (rad_ssum),
		.root     (rad_root)
	);

	// Choice of parameter and colour pair.
	logic [F:0]  t_sel;
	logic [F:0]  t_st, tw_st;
	logic [23:0] c1_st, c2_st;

	always_comb begin
		unique case (fill_mode_q)
			sgf_pkg::MODE_LINEAR: t_sel = lin_sat ? ONE_T : {1'b0, lin_quo};
			sgf_pkg::MODE_RADIAL: t_sel = (rad_root > ONE_T) ? ONE_T : rad_root;
			default:              t_sel = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[ST_T]) begin
			t_st  <= t_sel;
			tw_st <= ONE_T - t_sel;
			c1_st <= meta[ST_T-1].border ? border_a_q : inside_a_q;
			c2_st <= meta[ST_T-1].border ? border_b_q : inside_b_q;
		end
	end

	// Channel weights, red in the top byte of each colour.
	logic [F+8:0] wa_sprod [3];
	logic [F+8:0] wb_sprod [3];

	for (genvar c = 0; c < 3; c++) begin : g_chan
		always_ff @(posedge clk) begin
			if (en[ST_PROD]) begin
				wa_sprod[c] <= (F+9)'(c1_st[23-8*c -: 8]) * (F+9)'(tw_st);
				wb_sprod[c] <= (F+9)'(c2_st[23-8*c -: 8]) * (F+9)'(t_st);
			end
		end
	end

	logic [F+8:0] mix [3];
	logic [7:0]   red_sout, green_sout, blue_sout, alpha_sout;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			mix[c] = wa_sprod[c] + wb_sprod[c] + ROUND_HF;
		end
	end

	// Hints pass unchanged, outside pixels become transparent black, the rest are painted.
	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			priority if (meta[ST_OUT-1].hint) begin
				red_sout   <= meta[ST_OUT-1].red;
				green_sout <= meta[ST_OUT-1].green;
				blue_sout  <= meta[ST_OUT-1].blue;
				alpha_sout <= meta[ST_OUT-1].alpha;
			end else if (meta[ST_OUT-1].outside) begin
				red_sout   <= '0;
				green_sout <= '0;
				blue_sout  <= '0;
				alpha_sout <= '0;
			end else begin
				red_sout   <= mix[0][F+7:F];
				green_sout <= mix[1][F+7:F];
				blue_sout  <= mix[2][F+7:F];
				alpha_sout <= 8'hFF;
			end
		end
	end

	assign filtered.valid     = valid[STAGES-1];
	assign filtered.red_out   = red_sout;
	assign filtered.green_out = green_sout;
	assign filtered.blue_out  = blue_sout;
	assign filtered.alpha_out = alpha_sout;

endmodule

@@ hw/rtl/sgf_ctrl.sv @@
// Pipeline control of the symbol gradient fill: valid bits, per-stage enables and the
// side line that carries each pixel's own fields. Depends on sgf_pkg.
module sgf_ctrl #(
	parameter int STAGES = 39
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sgf_pkg::pix_meta_t meta_in,
	input  logic               out_ready,
	output logic [STAGES-1:0]  valid,
	output logic [STAGES-1:0]  en,
	output sgf_pkg::pix_meta_t meta [STAGES]
);

	logic [STAGES-1:0] valid_q;
	logic [STAGES:0]   rdy;
	logic [STAGES-1:0] valid_next;

	// A stage may load when it is empty or when its successor moves on, so bubbles close up.
	assign rdy[STAGES] = out_ready;
	assign valid_next  = {valid_q[STAGES-2:0], in_valid};
	assign in_ready    = rdy[0];
	assign valid       = valid_q;
	assign en          = rdy[STAGES-1:0];

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		assign rdy[i] = !valid_q[i] || rdy[i+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[i] <= 1'b0;
			end else if (rdy[i]) begin
				valid_q[i] <= valid_next[i];
			end
		end

		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (rdy[i]) begin
					meta[i] <= meta_in;
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (rdy[i]) begin
					meta[i] <= meta[i-1];
				end
			end
		end
	end

endmodule

@@ hw/rtl/sgf_fdiv.sv @@
// Pipelined restoring divider giving floor(num * 2^STEPS / den) for num below den,
// one quotient bit per stage, with a flag carried alongside. No package dependency.
module sgf_fdiv #(
	parameter int W     = 13,
	parameter int STEPS = 16
) (
	input  logic             clk,
	input  logic [STEPS-1:0] en,
	input  logic [W-1:0]     num,
	input  logic [W-1:0]     den,
	input  logic             sat_in,
	output logic [STEPS-1:0] quo,
	output logic             sat_out
);

	logic [W-1:0]     rem_s [STEPS];
	logic [W-1:0]     den_s [STEPS];
	logic [STEPS-1:0] quo_s [STEPS];
	logic             sat_s [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [W-1:0]     rem_p;
		logic [W-1:0]     den_p;
		logic [STEPS-1:0] quo_p;
		logic             sat_p;
		logic [W:0]       sh;
		logic [W:0]       diff;
		logic             ge;

		if (k == 0) begin : g_head
			assign rem_p = num;
			assign den_p = den;
			assign quo_p = '0;
			assign sat_p = sat_in;
		end else begin : g_body
			assign rem_p = rem_s[k-1];
			assign den_p = den_s[k-1];
			assign quo_p = quo_s[k-1];
			assign sat_p = sat_s[k-1];
		end

		always_comb begin
			sh   = {rem_p, 1'b0};
			ge   = sh >= {1'b0, den_p};
			diff = ge ? (sh - {1'b0, den_p}) : sh;
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= diff[W-1:0];
				den_s[k] <= den_p;
				quo_s[k] <= {quo_p[STEPS-2:0], ge};
				sat_s[k] <= sat_p;
			end
		end
	end

	assign quo     = quo_s[STEPS-1];
	assign sat_out = sat_s[STEPS-1];

endmodule

@@ hw/rtl/sgf_isqrt.sv @@
// Pipelined integer square root, one result bit per stage, floor of the true root.
// No package dependency.
module sgf_isqrt #(
	parameter int RB = 17
) (
	input  logic            clk,
	input  logic [RB-1:0]   en,
	input  logic [2*RB-1:0] radicand,
	output logic [RB-1:0]   root
);

	logic [RB:0]     rem_s  [RB];
	logic [RB-1:0]   root_s [RB];
	logic [2*RB-1:0] rad_s  [RB];

	for (genvar k = 0; k < RB; k++) begin : g_step
		logic [RB:0]     rem_p;
		logic [RB-1:0]   root_p;
		logic [2*RB-1:0] rad_p;
		logic [RB+2:0]   rw;
		logic [RB+2:0]   trial;
		logic [RB+2:0]   diff;
		logic            ge;

		if (k == 0) begin : g_head
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = radicand;
		end else begin : g_body
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign rad_p  = rad_s[k-1];
		end

		always_comb begin
			rw    = {rem_p, rad_p[2*RB-1 -: 2]};
			trial = {1'b0, root_p, 2'b01};
			ge    = rw >= trial;
			diff  = ge ? (rw - trial) : rw;
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k]  <= diff[RB:0];
				root_s[k] <= {root_p[RB-2:0], ge};
				rad_s[k]  <= {rad_p[2*RB-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[RB-1];

endmodule

@@ hw/rtl/sgf_checker.sv @@
// Port checks of the symbol gradient fill and the bind that attaches them to the top level.
// Depends only on the ports of symbol_gradient_fill.
module sgf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] red_out,
	input logic [7:0] alpha_out,
	input logic       cfg_ready
);

	// A result that is not taken stays offered with its red and alpha unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(alpha_out))
		else $error("result changed while stalled");

	// The input only backs up once every stage is full behind a stalled result.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input refused without an output stall");

	// Register writes are never refused.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("register write refused");

	// With the output free, a request offered now is always taken.
	a_in_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && out_ready |-> in_ready)
		else $error("request refused with the output free");

endmodule

bind symbol_gradient_fill sgf_checker u_sgf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel.valid),
	.in_ready  (pixel.ready),
	.out_valid (filtered.valid),
	.out_ready (filtered.ready),
	.red_out   (filtered.red_out),
	.alpha_out (filtered.alpha_out),
	.cfg_ready (cfg.ready)
);

@@ tb/symbol_gradient_fill_test.sv @@
// Self-checking testbench for symbol_gradient_fill: random and directed pixel requests
// checked against an in-bench colour predictor. Depends on sgf_pkg and the sgf_if interfaces.
module symbol_gradient_fill_test;

	localparam int CB = sgf_pkg::COORD_BITS_DEF;
	localparam int FB = sgf_pkg::FRAC_BITS_DEF;
	localparam longint ONE = longint'(1) << FB;
	localparam int LATENCY = 2 * FB + 7;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} pixel_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} colour_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sgf_pix_in_if #(.COORD_BITS(CB)) pixel ();
	sgf_pix_out_if filtered ();
	sgf_cfg_if cfg ();

	symbol_gradient_fill #(.COORD_BITS(CB), .FRAC_BITS(FB)) i_dut (
		.clk(clk), .arst_n(arst_n), .pixel(pixel), .filtered(filtered), .cfg(cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The predictor's own copy of the registers.
	logic [1:0]  mode_q;
	logic [23:0] in_a_q, in_b_q, edge_a_q, edge_b_q;
	logic [31:0] centre_q, end_q;
	logic [28:0] dims_q;

	pixel_t  pending_pixels[$];
	colour_t expected_colours[$];
	int errors = 0;
	int checked = 0;
	longint cycles = 0;
	int painted = 0, hints = 0, outsides = 0;

	// Stimulus controls, set by the initial block.
	bit sender_calm = 1'b0;
	bit receiver_calm = 1'b0;
	int hold_receiver = 0;

	// Signed Q2.14 to fraction units, rounding toward minus infinity.
	function automatic longint q14_frac(input logic [15:0] h);
		longint s;
		s = longint'($signed(h));
		return (s * ONE) >>> 14;
	endfunction

	function automatic longint position_frac(input logic [CB-1:0] p, input logic [12:0] sz);
		longint d, q;
		d = (sz == 0) ? 1 : longint'(sz);
		q = (longint'(p) << FB) / d;
		return (q >= ONE) ? ONE - 1 : q;
	endfunction

	function automatic longint root_floor(input longint s);
		longint lo, hi, mid;
		lo = 0;
		hi = 32'hFFFF_FFFF;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= s) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic logic [7:0] blend(input logic [7:0] c1, input logic [7:0] c2,
			input longint t);
		longint sum;
		sum = longint'(c1) * (ONE - t) + longint'(c2) * t + (ONE >> 1);
		return 8'(sum >> FB);
	endfunction

	function automatic colour_t paint_pixel(input pixel_t p);
		colour_t c;
		logic [23:0] c1, c2;
		longint u, v, cx, cy, ex, ey, dot, len, t, du, dv;
		t = 0;
		if (p.r != p.b) return '{p.r, p.g, p.b, p.a};
		if (p.g != 0 && p.r == 0) return '0;
		c1 = (p.g == 0) ? in_a_q : edge_a_q;
		c2 = (p.g == 0) ? in_b_q : edge_b_q;
		if (mode_q == sgf_pkg::MODE_LINEAR || mode_q == sgf_pkg::MODE_RADIAL) begin
			u = position_frac(p.x, dims_q[12:0]);
			v = position_frac(p.y, dims_q[28:16]);
			if (mode_q == sgf_pkg::MODE_LINEAR) begin
				cx = q14_frac(centre_q[15:0]);
				cy = q14_frac(centre_q[31:16]);
				ex = q14_frac(end_q[15:0]) - cx;
				ey = q14_frac(end_q[31:16]) - cy;
				dot = (u - cx) * ex + (v - cy) * ey;
				if (dot < 0) dot = -dot;
				len = ex * ex + ey * ey;
				if (len == 0) len = ONE * ONE;
				// The dot product is below 2^38 and the shift keeps it inside 64 bits.
				if (dot >= len) t = ONE;
				else t = longint'((128'(dot) << FB) / 128'(len));
			end else begin
				du = u - ONE / 2;
				dv = v - ONE / 2;
				t = root_floor(2 * (du * du + dv * dv));
				if (t > ONE) t = ONE;
			end
		end
		c.r = blend(c1[23:16], c2[23:16], t);
		c.g = blend(c1[15:8], c2[15:8], t);
		c.b = blend(c1[7:0], c2[7:0], t);
		c.a = 8'hFF;
		return c;
	endfunction

	// Driver: pending pixels are offered at the clock edge, with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel.valid <= 1'b0;
		end else begin
			if (pixel.valid && pixel.ready) begin
				expected_colours.push_back(paint_pixel(pending_pixels.pop_front()));
			end
			if ((pixel.valid && !pixel.ready) ||
					(pending_pixels.size() > 0 &&
					(sender_calm || $urandom_range(99) >= 34))) begin
				// A stalled request stays as it is; otherwise the head of the queue goes out.
				if (!(pixel.valid && !pixel.ready)) begin
					{pixel.x_pos, pixel.y_pos, pixel.red_in, pixel.green_in,
						pixel.blue_in, pixel.alpha_in} <= pending_pixels[0];
				end
				pixel.valid <= 1'b1;
			end else begin
				pixel.valid <= 1'b0;
			end
		end
	end

	// Monitor: compares every accepted result with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		colour_t want;
		if (!arst_n) begin
			filtered.ready <= 1'b0;
		end else begin
			cycles <= cycles + 1;
			if (filtered.valid && filtered.ready) begin
				if (expected_colours.size() == 0) begin
					$error("unexpected result %h", {filtered.red_out, filtered.green_out,
						filtered.blue_out, filtered.alpha_out});
					errors++;
				end else begin
					want = expected_colours.pop_front();
					checked <= checked + 1;
					if (filtered.red_out !== want.r) begin
						$error("red_out expected %0d got %0d", want.r, filtered.red_out);
						errors++;
					end
					if (filtered.green_out !== want.g) begin
						$error("green_out expected %0d got %0d", want.g, filtered.green_out);
						errors++;
					end
					if (filtered.blue_out !== want.b) begin
						$error("blue_out expected %0d got %0d", want.b, filtered.blue_out);
						errors++;
					end
					if (filtered.alpha_out !== want.a) begin
						$error("alpha_out expected %0d got %0d", want.a, filtered.alpha_out);
						errors++;
					end
				end
			end
			// A long hold-off is counted down here so the block backs up into its input.
			if (hold_receiver > 0) begin
				hold_receiver <= hold_receiver - 1;
				filtered.ready <= 1'b0;
			end else begin
				filtered.ready <= receiver_calm || ($urandom_range(99) >= 34);
			end
		end
	end

	// The run is ended here if something has hung.
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Register writes happen only with nothing in flight, and the mirror follows each one.
	task automatic write_reg(input logic [sgf_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [31:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			sgf_pkg::REG_FILL_MODE:      mode_q = val[1:0];
			sgf_pkg::REG_INSIDE_COLOR_A: in_a_q = val[23:0];
			sgf_pkg::REG_INSIDE_COLOR_B: in_b_q = val[23:0];
			sgf_pkg::REG_EDGE_COLOR_A:   edge_a_q = val[23:0];
			sgf_pkg::REG_EDGE_COLOR_B:   edge_b_q = val[23:0];
			sgf_pkg::REG_CENTER_POINT:   centre_q = val;
			sgf_pkg::REG_END_POINT:      end_q = val;
			default:                     dims_q = val[28:0];
		endcase
	endtask

	// Waits until every request has been delivered and the pipe has drained.
	task automatic drain();
		wait (pending_pixels.size() == 0 && !pixel.valid && expected_colours.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic pixel_t random_pixel();
		pixel_t p;
		logic [7:0] rb;
		p.x = CB'($urandom);
		p.y = CB'($urandom);
		p.a = 8'($urandom);
		rb = 8'($urandom);
		case ($urandom_range(9))
			0, 1:    begin p.r = 8'($urandom); p.b = 8'($urandom); p.g = 8'($urandom); end // hint
			2:       begin p.r = 0; p.b = 0; p.g = 8'($urandom_range(255, 1)); end // outside
			3, 4, 5: begin p.r = rb; p.b = rb; p.g = 0; end                    // inside
			default: begin
				p.r = (rb == 0) ? 8'd1 : rb;
				p.b = p.r;
				p.g = 8'($urandom_range(255, 1));
			end
		endcase
		// Mostly positions inside the image, sometimes anything at all.
		if ($urandom_range(3) != 0 && dims_q[12:0] != 0)
			p.x = CB'($urandom_range(dims_q[12:0] - 1));
		if ($urandom_range(3) != 0 && dims_q[28:16] != 0)
			p.y = CB'($urandom_range(dims_q[28:16] - 1));
		if (p.r != p.b) hints++;
		else if (p.g != 0 && p.r == 0) outsides++;
		else painted++;
		return p;
	endfunction

	function automatic logic [28:0] random_dims();
		logic [12:0] w, h;
		case ($urandom_range(3))
			0:       begin w = 13'($urandom); h = 13'($urandom); end
			1:       begin w = 0; h = 13'h1FFF; end
			default: begin w = 13'($urandom_range(300, 1)); h = 13'($urandom_range(300, 1)); end
		endcase
		return {h, 3'b000, w};
	endfunction

	initial begin
		logic [31:0] val;
		int phase;
		cfg.valid = 1'b0;
		cfg.index = sgf_pkg::REG_FILL_MODE;
		cfg.data = '0;
		pixel.x_pos = '0;
		pixel.y_pos = '0;
		pixel.red_in = '0;
		pixel.green_in = '0;
		pixel.blue_in = '0;
		pixel.alpha_in = '0;
		mode_q = sgf_pkg::MODE_SOLID;
		in_a_q = '0;
		in_b_q = '0;
		edge_a_q = '0;
		edge_b_q = '0;
		centre_q = sgf_pkg::CENTER_RESET;
		end_q = sgf_pkg::END_RESET;
		dims_q = sgf_pkg::DIMS_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset values first, then each mode with extreme colours and positions.
		pending_pixels.push_back('{12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 8'hFF});
		pending_pixels.push_back('{12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'h00, 8'h00});
		pending_pixels.push_back('{12'd5, 12'd9, 8'd0, 8'hFF, 8'd0, 8'h5A});
		drain();
		write_reg(sgf_pkg::REG_INSIDE_COLOR_A, 32'hFFFF_FFFF);
		write_reg(sgf_pkg::REG_INSIDE_COLOR_B, 32'h0000_0000);
		write_reg(sgf_pkg::REG_EDGE_COLOR_A, 32'h0012_34AB);
		write_reg(sgf_pkg::REG_EDGE_COLOR_B, 32'h00FF_00FF);
		for (int m = 0; m < 4; m++) begin
			write_reg(sgf_pkg::REG_FILL_MODE, m);
			pending_pixels.push_back('{12'd0, 12'd0, 8'hFF, 8'd0, 8'hFF, 8'd0});
			pending_pixels.push_back('{12'd255, 12'd255, 8'd1, 8'd1, 8'd1, 8'd7});
			pending_pixels.push_back('{12'd128, 12'd128, 8'd9, 8'd0, 8'd9, 8'd0});
			pending_pixels.push_back('{12'hFFF, 12'd0, 8'd3, 8'hFF, 8'd3, 8'hFF});
			drain();
		end
		// Zero-length gradient, zero dimensions and extreme points.
		write_reg(sgf_pkg::REG_FILL_MODE, 32'(sgf_pkg::MODE_LINEAR));
		write_reg(sgf_pkg::REG_END_POINT, sgf_pkg::CENTER_RESET);
		write_reg(sgf_pkg::REG_IMAGE_DIMS, 32'd0);
		pending_pixels.push_back('{12'd0, 12'd0, 8'd4, 8'd0, 8'd4, 8'd0});
		pending_pixels.push_back('{12'd77, 12'd3, 8'd4, 8'd2, 8'd4, 8'd0});
		drain();
		write_reg(sgf_pkg::REG_CENTER_POINT, 32'h8000_8000);
		write_reg(sgf_pkg::REG_END_POINT, 32'h7FFF_7FFF);
		write_reg(sgf_pkg::REG_IMAGE_DIMS, 32'h1FFF_1FFF);
		pending_pixels.push_back('{12'hFFF, 12'hFFF, 8'd6, 8'd0, 8'd6, 8'd0});
		pending_pixels.push_back('{12'd0, 12'hABC, 8'd6, 8'd1, 8'd6, 8'd0});
		drain();

		// Random phases, each under its own register setting.
		for (phase = 0; phase < 12; phase++) begin
			write_reg(sgf_pkg::REG_FILL_MODE, (phase < 2) ? phase + 1 : $urandom_range(3));
			write_reg(sgf_pkg::REG_INSIDE_COLOR_A, $urandom);
			write_reg(sgf_pkg::REG_INSIDE_COLOR_B, $urandom);
			write_reg(sgf_pkg::REG_EDGE_COLOR_A, $urandom);
			write_reg(sgf_pkg::REG_EDGE_COLOR_B, $urandom);
			val = $urandom;
			if ($urandom_range(3) == 0) val = {16'($urandom_range(16384)), 16'd0} |
				32'($urandom_range(16384));
			write_reg(sgf_pkg::REG_CENTER_POINT, val);
			write_reg(sgf_pkg::REG_END_POINT, ($urandom_range(5) == 0) ? val : $urandom);
			write_reg(sgf_pkg::REG_IMAGE_DIMS, 32'(random_dims()));
			sender_calm = (phase == 3);
			receiver_calm = (phase == 3);
			for (int i = 0; i < 100; i++) pending_pixels.push_back(random_pixel());
			// Partway through some phases the receiver stops for a long stretch.
			if (phase % 4 == 1) begin
				wait (pending_pixels.size() < 70);
				hold_receiver = 3 * LATENCY;
			end
			// Every phase ends with the sender paused until every result is back.
			drain();
		end

		repeat (LATENCY + 10) @(posedge clk);
		$display("pixels checked: %0d (%0d painted, %0d hints, %0d outside)",
			checked, painted, hints, outsides);
		$display("covered solid, linear and radial fills, stalls, zero sizes and lengths");
		if (errors == 0 && expected_colours.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
